// ===== design/slm_pkg.sv =====
// ----------------------------------------------------------------------------
// slm_pkg: shared definitions for the sorted list merge block
// Sizes, command kind codes, controller states and the control/status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package slm_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int DATA_W     = 32;
    localparam int KIND_W     = 2;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LIST_DEPTH);

    localparam logic [KIND_W-1:0] KIND_LOAD_A = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_B = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MERGE  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic start;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic total_zero;
        logic out_free;
        logic last_pick;
    } status_t;

endpackage

// ===== design/slm_ctrl.sv =====
// ----------------------------------------------------------------------------
// slm_ctrl: merge controller
// Accepts load and merge beats while idle, then steps the datapath through
// fetch and emit states per merged element, waiting for a free output.
// ----------------------------------------------------------------------------
module slm_ctrl
    import slm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [KIND_W-1:0] kind,
    input  status_t           st,
    output logic              in_ready,
    output cmd_t              cmd,
    output state_t            state
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (kind)
                        KIND_LOAD_A: cmd.load_a = 1'b1;
                        KIND_LOAD_B: cmd.load_b = 1'b1;
                        KIND_MERGE:
                        begin
                            cmd.start = 1'b1;
                            if (!st.total_zero)
                            begin
                                state_next = ST_FETCH;
                            end
                        end
                        default: cmd = '0;
                    endcase
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = st.last_pick ? ST_IDLE : ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign state = state_reg;

endmodule

// ===== design/slm_dpath.sv =====
// ----------------------------------------------------------------------------
// slm_dpath: list stores, counters, merge pointers and output register
// Holds both lists in memories with registered reads, picks the smaller
// head on each emit with B winning ties, and keeps the result beat until it is taken.
// ----------------------------------------------------------------------------
module slm_dpath
    import slm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    input  logic [DATA_W-1:0] value,
    input  logic              out_ready,
    output status_t           st,
    output logic              out_valid,
    output logic [DATA_W-1:0] merged_value,
    output logic              last,
    output logic              overflow
);

    logic [DATA_W-1:0] store_a [LIST_DEPTH];
    logic [DATA_W-1:0] store_b [LIST_DEPTH];
    logic [DATA_W-1:0] rd_a_reg;
    logic [DATA_W-1:0] rd_b_reg;

    logic [CNT_W-1:0]  count_a_reg;
    logic [CNT_W-1:0]  count_b_reg;
    logic              flag_reg;
    logic [CNT_W-1:0]  len_a_reg;
    logic [CNT_W-1:0]  len_b_reg;
    logic [SUM_W-1:0]  total_reg;
    logic              snap_flag_reg;
    logic [CNT_W-1:0]  ptr_a_reg;
    logic [CNT_W-1:0]  ptr_b_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_last_reg;
    logic              out_ovf_reg;

    logic              room_a;
    logic              room_b;
    logic              take_a;
    logic [SUM_W-1:0]  done_next;

    assign room_a = count_a_reg < DEPTH_CNT;
    assign room_b = count_b_reg < DEPTH_CNT;

    assign take_a = (ptr_a_reg < len_a_reg)
                 && ((ptr_b_reg >= len_b_reg) || ($signed(rd_a_reg) < $signed(rd_b_reg)));

    assign done_next = SUM_W'(ptr_a_reg) + SUM_W'(ptr_b_reg) + SUM_W'(1);

    assign st.total_zero = (count_a_reg == '0) && (count_b_reg == '0);
    assign st.out_free   = !out_valid_reg || out_ready;
    assign st.last_pick  = (done_next == total_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_a && room_a)
        begin
            store_a[count_a_reg[IDX_W-1:0]] <= value;
        end
        if (cmd.load_b && room_b)
        begin
            store_b[count_b_reg[IDX_W-1:0]] <= value;
        end
        rd_a_reg <= store_a[ptr_a_reg[IDX_W-1:0]];
        rd_b_reg <= store_b[ptr_b_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            flag_reg      <= 1'b0;
            ptr_a_reg     <= '0;
            ptr_b_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_a)
            begin
                if (room_a)
                begin
                    count_a_reg <= count_a_reg + CNT_W'(1);
                end
                else
                begin
                    flag_reg <= 1'b1;
                end
            end
            if (cmd.load_b)
            begin
                if (room_b)
                begin
                    count_b_reg <= count_b_reg + CNT_W'(1);
                end
                else
                begin
                    flag_reg <= 1'b1;
                end
            end
            if (cmd.start)
            begin
                count_a_reg <= '0;
                count_b_reg <= '0;
                flag_reg    <= 1'b0;
                ptr_a_reg   <= '0;
                ptr_b_reg   <= '0;
            end
            if (cmd.emit)
            begin
                if (take_a)
                begin
                    ptr_a_reg <= ptr_a_reg + CNT_W'(1);
                end
                else
                begin
                    ptr_b_reg <= ptr_b_reg + CNT_W'(1);
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            len_a_reg     <= count_a_reg;
            len_b_reg     <= count_b_reg;
            total_reg     <= SUM_W'(count_a_reg) + SUM_W'(count_b_reg);
            snap_flag_reg <= flag_reg;
        end
        if (cmd.emit)
        begin
            out_value_reg <= take_a ? rd_a_reg : rd_b_reg;
            out_last_reg  <= st.last_pick;
            out_ovf_reg   <= snap_flag_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign merged_value = out_value_reg;
    assign last         = out_last_reg;
    assign overflow     = out_ovf_reg;

endmodule

// ===== design/sorted_list_merge_top.sv =====
// ----------------------------------------------------------------------------
// sorted_list_merge_top: two-way merge of two sorted signed lists
// Load beats are accepted while the controller is idle. For each element, a
// merge passes through a store read state and a compare and output state,
// and it waits in the output state while the sink holds the previous beat.
// Reset clears counts, overflow flag, controller and output valid; the list
// stores are not cleared and hold data only below the counts.
// ----------------------------------------------------------------------------
module sorted_list_merge_top
    import slm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [KIND_W-1:0]        kind,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] merged_value,
    output logic                     last,
    output logic                     overflow
);

    cmd_t              cmd;
    status_t           st;
    state_t            state;
    logic [DATA_W-1:0] merged_raw;

    slm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .st       (st),
        .in_ready (in_ready),
        .cmd      (cmd),
        .state    (state)
    );

    slm_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .value        (value),
        .out_ready    (out_ready),
        .st           (st),
        .out_valid    (out_valid),
        .merged_value (merged_raw),
        .last         (last),
        .overflow     (overflow)
    );

    assign merged_value = $signed(merged_raw);

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_a, cmd.load_b, cmd.start, cmd.emit}))
        else $error("more than one datapath command in a cycle");

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> st.out_free)
        else $error("emit while the output register is still occupied");

    a_start_fetches: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start && !st.total_zero) |=> (state == ST_FETCH && !in_ready))
        else $error("nonempty merge did not begin fetching");

    a_last_ends_merge: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && st.last_pick) |=> (state == ST_IDLE && out_valid && last))
        else $error("final merged beat did not end the merge");

endmodule
